>>> sv/eils_pkg.sv
package eils_pkg;

    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 20;
    localparam int PIN_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10000);

    // pin readings
    localparam logic [PIN_W-1:0] LEVEL_LOW  = 2'd0;
    localparam logic [PIN_W-1:0] LEVEL_HIGH = 2'd1;
    localparam logic [PIN_W-1:0] LEVEL_NONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd2;

    typedef enum logic [1:0] {
        ACT_POLL  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_ACK   = 2'd2
    } t_action;

    typedef struct packed {
        logic              irq;
        logic              flag;
        logic [TIME_W-1:0] due;
    } t_line_res;

    // base + period, clamped at the top of the time range
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [PERIOD_W-1:0] period);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {{(TIME_W+1-PERIOD_W){1'b0}}, period};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

>>> sv/ext_interrupt_line_sampler.sv
// an accepted input word passes the input, middle and output registers before its result word leaves on the master side
// throughput: one word per cycle while m_axis_tready allows; line state updates as a word leaves the input register
// the next-sample min/max compare sits in its own stage ahead of the output register
// reset (i_rst_n low, synchronous): pipeline emptied, flags and sample times cleared,
// no level known, forced sample pending, registers back to level mode and period 10000
module ext_interrupt_line_sampler import eils_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [PERIOD_W-1:0]    i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // now_us[63:0], pin_state0[65:64], pin_state1[67:66], ack_line[68], zero [71:69]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  logic [1:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // irq_line0[0], irq_line1[1], flag_line0[2], flag_line1[3],
    // next_sample_us[67:4], zero [71:68]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // configuration registers
    logic                r_edge_mode0;
    logic                r_edge_mode1;
    logic [PERIOD_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode0 <= 1'b0;
            r_edge_mode1 <= 1'b0;
            r_period     <= PERIOD_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_EDGE_MODE0: r_edge_mode0 <= i_cfg_data[0];
                REG_EDGE_MODE1: r_edge_mode1 <= i_cfg_data[0];
                REG_PERIOD:     r_period     <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // pipeline handshake: each stage moves when the next one is free or moving
    logic r_in_valid, r_mid_valid, r_out_valid;
    logic in_load, in_move, mid_move, mid_free, out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign mid_move      = r_mid_valid && out_free;
    assign mid_free      = !r_mid_valid || mid_move;
    assign in_move       = r_in_valid && mid_free;
    assign s_axis_tready = !r_in_valid || in_move;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // input register
    logic [1:0]        r_in_action;
    logic [TIME_W-1:0] r_in_now;
    logic [PIN_W-1:0]  r_in_pin0;
    logic [PIN_W-1:0]  r_in_pin1;
    logic              r_in_ack;

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_action <= s_axis_tuser;
            r_in_now    <= s_axis_tdata[63:0];
            r_in_pin0   <= s_axis_tdata[65:64];
            r_in_pin1   <= s_axis_tdata[67:66];
            r_in_ack    <= s_axis_tdata[68];
        end
    end

    // forced sample after reset or a reset action, spent by the next poll
    logic    r_force;
    t_action in_action;

    assign in_action = t_action'(r_in_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b1;
        end else if (in_move) begin
            case (in_action)
                ACT_POLL:  r_force <= 1'b0;
                ACT_RESET: r_force <= 1'b1;
                default: ;
            endcase
        end
    end

    // per-line sampling, edge flag and due time
    t_line_res line0_res;
    t_line_res line1_res;

    eils_line u_line0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_move),
        .i_action    (in_action),
        .i_now       (r_in_now),
        .i_pin       (r_in_pin0),
        .i_ack_hit   (!r_in_ack),
        .i_force     (r_force),
        .i_edge_mode (r_edge_mode0),
        .i_period    (r_period),
        .o_res       (line0_res)
    );

    eils_line u_line1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_move),
        .i_action    (in_action),
        .i_now       (r_in_now),
        .i_pin       (r_in_pin1),
        .i_ack_hit   (r_in_ack),
        .i_force     (r_force),
        .i_edge_mode (r_edge_mode1),
        .i_period    (r_period),
        .o_res       (line1_res)
    );

    // middle stage: line results and both due times
    t_line_res         r_mid_line0;
    t_line_res         r_mid_line1;
    logic [TIME_W-1:0] r_mid_now;

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_mid_line0 <= line0_res;
            r_mid_line1 <= line1_res;
            r_mid_now   <= r_in_now;
        end
    end

    // earliest due time, raised to the current time
    logic [TIME_W-1:0] earliest;
    logic [TIME_W-1:0] next_sample;

    assign earliest    = (r_mid_line0.due < r_mid_line1.due) ? r_mid_line0.due
                                                             : r_mid_line1.due;
    assign next_sample = (earliest > r_mid_now) ? earliest : r_mid_now;

    // output register
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (mid_move) begin
            r_out_data <= {4'b0000, next_sample,
                           r_mid_line1.flag, r_mid_line0.flag,
                           r_mid_line1.irq, r_mid_line0.irq};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (in_move) begin
                r_in_valid <= 1'b0;
            end
            if (in_move) begin
                r_mid_valid <= 1'b1;
            end else if (mid_move) begin
                r_mid_valid <= 1'b0;
            end
            if (mid_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> sv/eils_line.sv
module eils_line import eils_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_action             i_action,
    input  logic [TIME_W-1:0]   i_now,
    input  logic [PIN_W-1:0]    i_pin,
    input  logic                i_ack_hit,
    input  logic                i_force,
    input  logic                i_edge_mode,
    input  logic [PERIOD_W-1:0] i_period,
    output t_line_res           o_res
);

    logic [PIN_W-1:0]  r_prev, n_prev;
    logic              r_valid, n_valid;
    logic [TIME_W-1:0] r_time, n_time;
    logic              r_flag, n_flag;

    logic [TIME_W-1:0] elapsed;
    logic              throttled;
    logic              now_low;
    logic              falling;
    logic [TIME_W-1:0] due_old;
    logic [TIME_W-1:0] due_now;

    assign elapsed   = i_now - r_time;
    assign throttled = !i_force && r_valid &&
                       (elapsed < {{(TIME_W-PERIOD_W){1'b0}}, i_period});
    assign due_old   = sat_add(r_time, i_period);
    assign due_now   = sat_add(i_now, i_period);

    always_comb begin
        n_prev    = r_prev;
        n_valid   = r_valid;
        n_time    = r_time;
        n_flag    = r_flag;
        now_low   = (i_pin == LEVEL_LOW);
        falling   = r_valid && (r_prev != LEVEL_LOW) && now_low;
        o_res.irq = 1'b0;
        o_res.due = due_old;
        unique case (i_action)
            ACT_POLL: begin
                if (!throttled) begin
                    n_time    = i_now;
                    o_res.due = due_now;
                    // undriven or conflicting pin only moves the sample time
                    if (i_pin == LEVEL_LOW || i_pin == LEVEL_HIGH) begin
                        n_prev  = i_pin;
                        n_valid = 1'b1;
                        if (i_edge_mode) begin
                            if (falling) begin
                                n_flag = 1'b1;
                            end
                            o_res.irq = n_flag;
                        end else begin
                            o_res.irq = now_low;
                        end
                    end
                end
            end
            ACT_RESET: begin
                n_time    = '0;
                n_flag    = 1'b0;
                o_res.due = {{(TIME_W-PERIOD_W){1'b0}}, i_period};
            end
            ACT_ACK: begin
                if (i_ack_hit) begin
                    n_flag = 1'b0;
                end
            end
            default: ;
        endcase
        o_res.flag = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= LEVEL_NONE;
            r_valid <= 1'b0;
            r_time  <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_prev  <= n_prev;
            r_valid <= n_valid;
            r_time  <= n_time;
            r_flag  <= n_flag;
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import eils_pkg::*;

    // codes the block gives no name: spare action, conflicting pin reading
    localparam logic [1:0]       ACT_SPARE    = 2'd3;
    localparam logic [PIN_W-1:0] PIN_CONFLICT = 2'd3;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_WORDS     = 150;
    localparam int TAIL_WORDS      = 200;

    typedef struct packed {
        logic              irq0;
        logic              irq1;
        logic              flag0;
        logic              flag1;
        logic [TIME_W-1:0] next_us;
    } t_irq_result;

    // tracks the sampler state and holds the results still owed by the block
    class irq_result_board;
        bit                  trig_edge[2];
        logic [PERIOD_W-1:0] period;
        logic [PIN_W-1:0]    prev_pin[2];
        bit                  sample_ok[2];
        logic [TIME_W-1:0]   sampled_at[2];
        bit                  edge_seen[2];
        bit                  force_pending;
        t_irq_result         pending_results[$];
        int                  errors;

        function new();
            trig_edge     = '{0, 0};
            period        = PERIOD_RESET;
            prev_pin      = '{LEVEL_NONE, LEVEL_NONE};
            sample_ok     = '{0, 0};
            sampled_at    = '{0, 0};
            edge_seen     = '{0, 0};
            force_pending = 1'b1;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
            case (idx)
                REG_EDGE_MODE0: trig_edge[0] = value[0];
                REG_EDGE_MODE1: trig_edge[1] = value[0];
                REG_PERIOD:     period       = value;
                default: ;
            endcase
        endfunction

        // predict the result of one accepted input word
        function void take_word(logic [1:0] act, logic [TIME_W-1:0] now,
                                logic [PIN_W-1:0] pin0, logic [PIN_W-1:0] pin1,
                                logic ack);
            t_irq_result       r;
            bit                irq[2];
            bit                force_now;
            bit                was_low;
            bit                now_low;
            logic [PIN_W-1:0]  pin;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] due;
            logic [TIME_W-1:0] earliest;
            irq = '{0, 0};
            case (act)
                ACT_POLL: begin
                    force_now     = force_pending;
                    force_pending = 1'b0;
                    for (int k = 0; k < 2; k++) begin
                        // throttled: elapsed time wraps modulo 2^64
                        if (!force_now && sample_ok[k] &&
                            (now - sampled_at[k]) < TIME_W'(period))
                            continue;
                        sampled_at[k] = now;
                        pin = (k == 0) ? pin0 : pin1;
                        // undriven or conflicting pin only moves the sample time
                        if (pin != LEVEL_LOW && pin != LEVEL_HIGH)
                            continue;
                        was_low        = (prev_pin[k] == LEVEL_LOW);
                        now_low        = (pin == LEVEL_LOW);
                        if (trig_edge[k] && sample_ok[k] && !was_low && now_low)
                            edge_seen[k] = 1'b1;
                        prev_pin[k]    = pin;
                        sample_ok[k]   = 1'b1;
                        irq[k] = trig_edge[k] ? edge_seen[k] : now_low;
                    end
                end
                ACT_RESET: begin
                    // level history and valid bits survive
                    sampled_at    = '{0, 0};
                    edge_seen     = '{0, 0};
                    force_pending = 1'b1;
                end
                ACT_ACK: edge_seen[ack] = 1'b0;
                default: ;
            endcase
            earliest = '1;
            for (int k = 0; k < 2; k++) begin
                sum = {1'b0, sampled_at[k]} + (TIME_W + 1)'(period);
                due = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                if (due < earliest)
                    earliest = due;
            end
            r.irq0    = irq[0];
            r.irq1    = irq[1];
            r.flag0   = edge_seen[0];
            r.flag1   = edge_seen[1];
            r.next_us = (earliest > now) ? earliest : now;
            pending_results.push_back(r);
        endfunction

        function void match_result(logic [OUT_DATA_W-1:0] word);
            t_irq_result want;
            if (pending_results.size() == 0) begin
                $error("result word arrived with no result expected");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (word[0] !== want.irq0) begin
                $error("irq_line0: expected %0d, actual %0d", want.irq0, word[0]);
                errors++;
            end
            if (word[1] !== want.irq1) begin
                $error("irq_line1: expected %0d, actual %0d", want.irq1, word[1]);
                errors++;
            end
            if (word[2] !== want.flag0) begin
                $error("flag_line0: expected %0d, actual %0d", want.flag0, word[2]);
                errors++;
            end
            if (word[3] !== want.flag1) begin
                $error("flag_line1: expected %0d, actual %0d", want.flag1, word[3]);
                errors++;
            end
            if (word[TIME_W+3:4] !== want.next_us) begin
                $error("next_sample_us: expected %0h, actual %0h", want.next_us,
                       word[TIME_W+3:4]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [PERIOD_W-1:0]   i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    irq_result_board board = new();

    // shared knobs between the stimulus and the receiver
    bit                idling_on;
    bit                hold_off_req;
    // stimulus time base and current pin levels
    logic [TIME_W-1:0] clock_us;
    logic [PIN_W-1:0]  pin_level[2];

    ext_interrupt_line_sampler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2000000;
        $display("ext_interrupt_line_sampler regression: fail");
        $finish;
    end

    // result side: ready changes on the falling edge, bursts of back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                // long stall so the pipe fills and the input side backs up
                hold_off_req  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // every accepted result word is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.match_result(m_axis_tdata);
    end

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wen  = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_wen  = 1'b0;
        board.write_reg(idx, value);
    endtask

    task automatic program_phase(bit mode0, bit mode1, logic [PERIOD_W-1:0] period);
        program_reg(REG_EDGE_MODE0, PERIOD_W'(mode0));
        program_reg(REG_EDGE_MODE1, PERIOD_W'(mode1));
        program_reg(REG_PERIOD, period);
    endtask

    // offer one word, hold it until the block takes it
    task automatic send_word(logic [1:0] act, logic [TIME_W-1:0] now,
                             logic [PIN_W-1:0] pin0, logic [PIN_W-1:0] pin1, logic ack);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = IN_DATA_W'({ack, pin1, pin0, now});
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_word(act, now, pin0, pin1, ack);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // sender pause: wait for every owed result, then let the pipe settle
    task automatic drain();
        stop_sending();
        while (board.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // mostly polls with time creeping around the period, some jumps and controls
    task automatic send_random(int count);
        int                  sel;
        int                  step;
        logic [1:0]          act;
        logic [PIN_W-1:0]    pin[2];
        logic [PERIOD_W-1:0] period;
        for (int n = 0; n < count; n++) begin
            period = board.period;
            sel = $urandom_range(0, 99);
            if (sel < 84)
                act = ACT_POLL;
            else if (sel < 91)
                act = ACT_ACK;
            else if (sel < 97)
                act = ACT_RESET;
            else
                act = ACT_SPARE;
            step = $urandom_range(0, 19);
            if (step == 0)
                clock_us = {$urandom, $urandom};
            else if (step == 1)
                clock_us = '1 - TIME_W'($urandom_range(0, 2 * period + 2));
            else if (step != 2)
                clock_us = clock_us + TIME_W'($urandom_range(0, 2 * period + 2));
            for (int k = 0; k < 2; k++) begin
                sel = $urandom_range(0, 39);
                if (sel == 0)
                    pin[k] = PIN_CONFLICT;
                else if (sel < 5)
                    pin[k] = LEVEL_NONE;
                else begin
                    if (sel < 18)
                        pin_level[k] = (pin_level[k] == LEVEL_LOW) ? LEVEL_HIGH : LEVEL_LOW;
                    pin[k] = pin_level[k];
                end
            end
            send_word(act, clock_us, pin[0], pin[1], 1'(
                $urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0] period;
        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_POLL;
        idling_on     = 1'b1;
        hold_off_req  = 1'b0;
        clock_us      = '0;
        pin_level     = '{LEVEL_HIGH, LEVEL_HIGH};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: line 0 on falling edge, line 1 on low level, reset period
        program_reg(REG_EDGE_MODE0, PERIOD_W'(1));
        // forced first sample, then a throttled poll that samples nothing
        send_word(ACT_POLL, 64'd0, LEVEL_HIGH, LEVEL_HIGH, 1'b0);
        send_word(ACT_POLL, 64'd5, LEVEL_LOW, LEVEL_LOW, 1'b0);
        // falling edge on line 0, level low on line 1
        send_word(ACT_POLL, 64'd10000, LEVEL_LOW, LEVEL_LOW, 1'b0);
        send_word(ACT_POLL, 64'd10001, LEVEL_HIGH, LEVEL_HIGH, 1'b1);
        // undriven and conflicting pins only move the sample time
        send_word(ACT_POLL, 64'd20000, LEVEL_NONE, LEVEL_NONE, 1'b0);
        send_word(ACT_POLL, 64'd30000, PIN_CONFLICT, PIN_CONFLICT, 1'b1);
        // acknowledge both lines, then the spare action code
        send_word(ACT_ACK, 64'd30001, LEVEL_LOW, LEVEL_LOW, 1'b0);
        send_word(ACT_ACK, 64'd30001, LEVEL_LOW, LEVEL_LOW, 1'b1);
        send_word(ACT_SPARE, 64'd30002, LEVEL_HIGH, LEVEL_LOW, 1'b1);
        // block reset forces the next poll
        send_word(ACT_RESET, 64'd40000, LEVEL_LOW, LEVEL_LOW, 1'b0);
        send_word(ACT_POLL, 64'd40001, LEVEL_HIGH, LEVEL_LOW, 1'b0);
        // near the top of time: due time saturates
        send_word(ACT_POLL, 64'hFFFF_FFFF_FFFF_FFF0, LEVEL_LOW, LEVEL_HIGH, 1'b0);
        send_word(ACT_POLL, 64'hFFFF_FFFF_FFFF_FFFF, LEVEL_HIGH, LEVEL_HIGH, 1'b1);
        // wrap back to zero stays inside the period
        send_word(ACT_POLL, 64'd0, LEVEL_LOW, LEVEL_LOW, 1'b0);
        send_word(ACT_POLL, 64'd20000, LEVEL_LOW, LEVEL_LOW, 1'b0);
        send_word(ACT_RESET, 64'hFFFF_FFFF_FFFF_FFFF, LEVEL_HIGH, LEVEL_HIGH, 1'b1);
        send_word(ACT_POLL, 64'd100, LEVEL_LOW, LEVEL_HIGH, 1'b0);
        send_word(ACT_POLL, 64'h5555_AAAA_5555_AAAA, LEVEL_HIGH, LEVEL_LOW, 1'b1);
        send_word(ACT_POLL, 64'hAAAA_5555_AAAA_5555, LEVEL_LOW, LEVEL_HIGH, 1'b0);
        drain();

        // fixed settings including the shortest period, a long one and zero
        program_phase(1'b1, 1'b1, PERIOD_W'(1));
        send_random(PHASE_WORDS / 2);
        drain();
        send_random(PHASE_WORDS / 2);
        drain();

        program_phase(1'b0, 1'b1, PERIOD_W'(1000000));
        clock_us = {$urandom, $urandom};
        hold_off_req = 1'b1;
        send_random(PHASE_WORDS);
        drain();

        program_phase(1'b1, 1'b0, PERIOD_W'(0));
        send_random(PHASE_WORDS);
        drain();

        program_phase(1'b0, 1'b0, PERIOD_RESET);
        send_random(PHASE_WORDS);
        drain();

        program_phase(1'b1, 1'b1, PERIOD_W'(500));
        hold_off_req = 1'b1;
        send_random(PHASE_WORDS);
        drain();

        // random settings, mostly short periods
        for (int p = 0; p < 3; p++) begin
            if ($urandom_range(0, 3) == 0)
                period = PERIOD_W'($urandom_range(1, 1000000));
            else
                period = PERIOD_W'($urandom_range(1, 64));
            program_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), period);
            clock_us = {$urandom, $urandom};
            send_random(PHASE_WORDS);
            drain();
        end

        // closing stretch at full rate on both sides
        idling_on = 1'b0;
        program_phase(1'b1, 1'b0, PERIOD_W'(16));
        send_random(TAIL_WORDS);
        drain();

        if (board.errors == 0)
            $display("ext_interrupt_line_sampler regression: pass");
        else
            $display("ext_interrupt_line_sampler regression: fail");
        $finish;
    end

endmodule
